@@ hw/rtl/elt_pkg.sv @@
// ----------------------------------------------------------------------------
// elt_pkg
// Types, constants and small functions shared by the luma tint mask blocks.
// ----------------------------------------------------------------------------
package elt_pkg;

  // field and register widths
  localparam int CfgSizeW  = 13;
  localparam int CoordW    = 12;
  localparam int LumaW     = 8;
  localparam int StyleW    = 3;
  localparam int QualW     = 2;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 13;

  // frame limits
  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  // geometry
  localparam int PctW      = 6;
  localparam int ProdW     = 18;   // frame size times a percentage
  localparam int RadW      = 11;   // radius, vertical center
  localparam int SqW       = 21;   // squared radius and offset
  localparam int QuoW      = 17;   // normalized distance term, Q1.16
  localparam int DistW     = 18;   // sum of two terms
  localparam int GainW     = 11;   // |tint sum| * 35
  localparam int MinRx     = 8;
  localparam int MinRy     = 10;
  localparam int UnitDist  = 65536;

  // floor(x / 100) for x below 2^18: exact with m = ceil(2^25 / 100)
  localparam int Div100Mul   = 335545;
  localparam int Div100Shift = 25;
  // floor(x / 100) for x below 2^11: exact with m = ceil(2^18 / 100)
  localparam int Div100SMul  = 2622;
  localparam int MagW        = 5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEffectEn    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTintStyle   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgQuality     = 3'd4;

  // quality codes
  localparam logic [QualW-1:0] QualLite     = 2'd0;
  localparam logic [QualW-1:0] QualBalanced = 2'd1;
  localparam logic [QualW-1:0] QualMax      = 2'd2;

  // tint style: |sum| * 35 and sign of the sum; unknown styles act neutral
  localparam logic [GainW-1:0] TintGain [8] = '{
    11'd0, 11'd1120, 11'd140, 11'd350, 11'd210, 11'd0, 11'd0, 11'd0
  };
  localparam logic TintNeg [8] = '{
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  typedef struct packed {
    logic [CfgSizeW-1:0] frame_width;
    logic [CfgSizeW-1:0] frame_height;
    logic                effect_enable;
    logic [StyleW-1:0]   tint_style;
    logic [QualW-1:0]    quality_level;
  } elt_cfg_t;

  typedef struct packed {
    logic [PctW-1:0] cy;
    logic [PctW-1:0] fx;
    logic [PctW-1:0] fy;
  } elt_pct_t;

  // sideband that rides along the distance pipeline
  typedef struct packed {
    logic [LumaW-1:0] luma;
    logic             qualify;
    logic             neg;
    logic [GainW-1:0] gain;
  } elt_side_t;

  typedef struct packed {
    elt_side_t       side;
    logic [SqW-1:0]  adx2;
    logic [SqW-1:0]  rx2;
    logic [SqW-1:0]  ady2;
    logic [SqW-1:0]  ry2;
  } elt_geo_t;

  typedef struct packed {
    elt_side_t       side;
    logic [QuoW-1:0] qx;
    logic [QuoW-1:0] qy;
  } elt_quo_t;

  typedef struct packed {
    logic [SqW-1:0] rem;
    logic           qbit;
  } elt_div_step_t;

  function automatic elt_pct_t quality_pct(input logic [QualW-1:0] q);
    elt_pct_t p;
    unique case (q)
      QualLite: begin
        p.cy = 6'd42; p.fx = 6'd18; p.fy = 6'd22;
      end
      QualMax: begin
        p.cy = 6'd40; p.fx = 6'd26; p.fy = 6'd32;
      end
      default: begin
        p.cy = 6'd42; p.fx = 6'd22; p.fy = 6'd28;
      end
    endcase
    return p;
  endfunction

  function automatic logic [RadW-1:0] div100(input logic [ProdW-1:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'(Div100Mul);
    return p[Div100Shift+RadW-1:Div100Shift];
  endfunction

  // one restoring division step: shift in a bit, subtract when it fits
  function automatic elt_div_step_t div_step(input logic [SqW-1:0] rem,
                                             input logic [SqW-1:0] den,
                                             input logic           nbit);
    logic [SqW:0]  trial;
    elt_div_step_t s;
    trial = {rem, nbit};
    if (trial >= {1'b0, den}) begin
      s.rem  = SqW'(trial - {1'b0, den});
      s.qbit = 1'b1;
    end else begin
      s.rem  = trial[SqW-1:0];
      s.qbit = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/elt_pix_if.sv @@
// ----------------------------------------------------------------------------
// elt_pix_if
// Pixel input channel: column, row and luma with valid/ready.
// ----------------------------------------------------------------------------
interface elt_pix_if;
  logic                      valid;
  logic                      ready;
  logic [elt_pkg::CoordW-1:0] pixel_col;
  logic [elt_pkg::CoordW-1:0] pixel_row;
  logic [elt_pkg::LumaW-1:0]  luma_in;

  modport source (output valid, output pixel_col, output pixel_row, output luma_in,
                  input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, input luma_in,
                  output ready);
endinterface

@@ hw/rtl/elt_res_if.sv @@
// ----------------------------------------------------------------------------
// elt_res_if
// Result channel: adjusted luma and the inside flag with valid/ready.
// ----------------------------------------------------------------------------
interface elt_res_if;
  logic                      valid;
  logic                      ready;
  logic [elt_pkg::LumaW-1:0] luma_out;
  logic                      inside_mask;

  modport source (output valid, output luma_out, output inside_mask, input ready);
  modport sink   (input valid, input luma_out, input inside_mask, output ready);
endinterface

@@ hw/rtl/elt_geom.sv @@
// ----------------------------------------------------------------------------
// elt_geom
// Four stages: ellipse geometry from the frame size, bounds test, offsets
// and squares feeding the distance divider.
// ----------------------------------------------------------------------------
module elt_geom (
  input  logic              clk,
  input  logic              rst_n,
  input  elt_pkg::elt_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [elt_pkg::CoordW-1:0] in_col,
  input  logic [elt_pkg::CoordW-1:0] in_row,
  input  logic [elt_pkg::LumaW-1:0]  in_luma,
  output logic              out_valid,
  input  logic              out_ready,
  output elt_pkg::elt_geo_t out_geo
);

  localparam int NStg = 4;

  logic [NStg-1:0] v_r;
  logic [NStg-1:0] en;

  // stage 0: clamp frame size, percent products, tint lookup
  logic [elt_pkg::LumaW-1:0]    luma0_r, luma1_r, luma2_r;
  logic [elt_pkg::CoordW-1:0]   col0_r, row0_r, col1_r, row1_r;
  logic [elt_pkg::CfgSizeW-1:0] w0_r, h0_r, w1_r, h1_r;
  logic [elt_pkg::CoordW-1:0]   xc0_r, xc1_r;
  logic [elt_pkg::ProdW-1:0]    pw0_r, pcy0_r, pfy0_r;
  logic                         act0_r, act1_r;
  logic                         neg0_r, neg1_r, neg2_r;
  logic [elt_pkg::GainW-1:0]    gain0_r, gain1_r, gain2_r;

  logic [elt_pkg::CfgSizeW-1:0] w_nxt, h_nxt;
  logic [elt_pkg::GainW-1:0]    gain_nxt;
  elt_pkg::elt_pct_t            pct;

  // stage 1
  logic [elt_pkg::RadW-1:0] rx1_r, ry1_r, yc1_r;
  logic [elt_pkg::RadW-1:0] rx_nxt, ry_nxt, yc_nxt;

  // stage 2
  logic [elt_pkg::RadW-1:0] adx2_r, ady2_r, rx2_r, ry2_r;
  logic                     qual2_r;
  logic [elt_pkg::CfgSizeW-1:0] col13, row13, xc13, yc13, rx13, ry13;
  logic [elt_pkg::CoordW-1:0]   adx_full, ady_full;
  logic                         x_ok, y_ok, qual_nxt;

  // stage 3
  elt_pkg::elt_geo_t geo3_r;
  logic [2*elt_pkg::RadW-1:0] sq_adx, sq_rx, sq_ady, sq_ry;

  always_comb begin
    en[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NStg-1];
  assign out_geo   = geo3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    w_nxt    = (cfg.frame_width > elt_pkg::CfgSizeW'(elt_pkg::MaxWidth)) ?
               elt_pkg::CfgSizeW'(elt_pkg::MaxWidth) : cfg.frame_width;
    h_nxt    = (cfg.frame_height > elt_pkg::CfgSizeW'(elt_pkg::MaxHeight)) ?
               elt_pkg::CfgSizeW'(elt_pkg::MaxHeight) : cfg.frame_height;
    pct      = elt_pkg::quality_pct(cfg.quality_level);
    gain_nxt = elt_pkg::TintGain[cfg.tint_style];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      luma0_r <= in_luma;
      col0_r  <= in_col;
      row0_r  <= in_row;
      w0_r    <= w_nxt;
      h0_r    <= h_nxt;
      xc0_r   <= w_nxt[elt_pkg::CfgSizeW-1:1];
      pw0_r   <= elt_pkg::ProdW'(w_nxt) * elt_pkg::ProdW'(pct.fx);
      pcy0_r  <= elt_pkg::ProdW'(h_nxt) * elt_pkg::ProdW'(pct.cy);
      pfy0_r  <= elt_pkg::ProdW'(h_nxt) * elt_pkg::ProdW'(pct.fy);
      act0_r  <= cfg.effect_enable && (gain_nxt != '0);
      neg0_r  <= elt_pkg::TintNeg[cfg.tint_style];
      gain0_r <= gain_nxt;
    end
  end

  // stage 1: divide the percent products by 100, apply radius minimums
  always_comb begin
    rx_nxt = elt_pkg::div100(pw0_r);
    ry_nxt = elt_pkg::div100(pfy0_r);
    yc_nxt = elt_pkg::div100(pcy0_r);
    if (rx_nxt < elt_pkg::RadW'(elt_pkg::MinRx)) rx_nxt = elt_pkg::RadW'(elt_pkg::MinRx);
    if (ry_nxt < elt_pkg::RadW'(elt_pkg::MinRy)) ry_nxt = elt_pkg::RadW'(elt_pkg::MinRy);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      luma1_r <= luma0_r;
      col1_r  <= col0_r;
      row1_r  <= row0_r;
      w1_r    <= w0_r;
      h1_r    <= h0_r;
      xc1_r   <= xc0_r;
      act1_r  <= act0_r;
      neg1_r  <= neg0_r;
      gain1_r <= gain0_r;
      rx1_r   <= rx_nxt;
      ry1_r   <= ry_nxt;
      yc1_r   <= yc_nxt;
    end
  end

  // stage 2: bounding box of the ellipse, clipped to the frame; absolute offsets
  always_comb begin
    col13 = elt_pkg::CfgSizeW'(col1_r);
    row13 = elt_pkg::CfgSizeW'(row1_r);
    xc13  = elt_pkg::CfgSizeW'(xc1_r);
    yc13  = elt_pkg::CfgSizeW'(yc1_r);
    rx13  = elt_pkg::CfgSizeW'(rx1_r);
    ry13  = elt_pkg::CfgSizeW'(ry1_r);
    x_ok  = (col13 + rx13 >= xc13) && (col13 < w1_r) && (col13 < xc13 + rx13);
    y_ok  = (row13 + ry13 >= yc13) && (row13 < h1_r) && (row13 < yc13 + ry13);
    qual_nxt = act1_r && x_ok && y_ok;
    adx_full = (col13 >= xc13) ? elt_pkg::CoordW'(col13 - xc13) :
                                 elt_pkg::CoordW'(xc13 - col13);
    ady_full = (row13 >= yc13) ? elt_pkg::CoordW'(row13 - yc13) :
                                 elt_pkg::CoordW'(yc13 - row13);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      luma2_r <= luma1_r;
      neg2_r  <= neg1_r;
      gain2_r <= gain1_r;
      qual2_r <= qual_nxt;
      rx2_r   <= rx1_r;
      ry2_r   <= ry1_r;
      // zero the offsets off the box so the divider stays in range
      adx2_r  <= qual_nxt ? adx_full[elt_pkg::RadW-1:0] : '0;
      ady2_r  <= qual_nxt ? ady_full[elt_pkg::RadW-1:0] : '0;
    end
  end

  // stage 3: squares
  always_comb begin
    sq_adx = adx2_r * adx2_r;
    sq_rx  = rx2_r * rx2_r;
    sq_ady = ady2_r * ady2_r;
    sq_ry  = ry2_r * ry2_r;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      geo3_r.side.luma    <= luma2_r;
      geo3_r.side.qualify <= qual2_r;
      geo3_r.side.neg     <= neg2_r;
      geo3_r.side.gain    <= gain2_r;
      geo3_r.adx2         <= sq_adx[elt_pkg::SqW-1:0];
      geo3_r.rx2          <= sq_rx[elt_pkg::SqW-1:0];
      geo3_r.ady2         <= sq_ady[elt_pkg::SqW-1:0];
      geo3_r.ry2          <= sq_ry[elt_pkg::SqW-1:0];
    end
  end

endmodule

@@ hw/rtl/elt_dist_div.sv @@
// ----------------------------------------------------------------------------
// elt_dist_div
// Pipelined restoring divider, two lanes: floor(d^2 * 2^16 / r^2) for the
// column and row offsets, one quotient bit per stage.
// ----------------------------------------------------------------------------
module elt_dist_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  elt_pkg::elt_geo_t in_geo,
  output logic              out_valid,
  input  logic              out_ready,
  output elt_pkg::elt_quo_t out_quo
);

  localparam int NStg = elt_pkg::QuoW;

  logic [NStg-1:0] v_r;
  logic [NStg-1:0] en;

  logic [elt_pkg::SqW-1:0]  rem_x_r [NStg];
  logic [elt_pkg::SqW-1:0]  den_x_r [NStg];
  logic [elt_pkg::QuoW-1:0] q_x_r   [NStg];
  logic [elt_pkg::SqW-1:0]  rem_y_r [NStg];
  logic [elt_pkg::SqW-1:0]  den_y_r [NStg];
  logic [elt_pkg::QuoW-1:0] q_y_r   [NStg];
  elt_pkg::elt_side_t       side_r  [NStg];

  logic [elt_pkg::SqW-1:0]  rem_x_in [NStg];
  logic [elt_pkg::SqW-1:0]  den_x_in [NStg];
  logic [elt_pkg::QuoW-1:0] q_x_in   [NStg];
  logic [elt_pkg::SqW-1:0]  rem_y_in [NStg];
  logic [elt_pkg::SqW-1:0]  den_y_in [NStg];
  logic [elt_pkg::QuoW-1:0] q_y_in   [NStg];
  elt_pkg::elt_side_t       side_in  [NStg];
  logic                     nbit_x   [NStg];
  logic                     nbit_y   [NStg];
  elt_pkg::elt_div_step_t   st_x     [NStg];
  elt_pkg::elt_div_step_t   st_y     [NStg];

  always_comb begin
    en[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NStg-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  // dividend is d^2 << 16: start from d^2 >> 1, shift in d^2[0], then zeros
  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      if (k == 0) begin
        rem_x_in[k] = in_geo.adx2 >> 1;
        den_x_in[k] = in_geo.rx2;
        q_x_in[k]   = '0;
        nbit_x[k]   = in_geo.adx2[0];
        rem_y_in[k] = in_geo.ady2 >> 1;
        den_y_in[k] = in_geo.ry2;
        q_y_in[k]   = '0;
        nbit_y[k]   = in_geo.ady2[0];
        side_in[k]  = in_geo.side;
      end else begin
        rem_x_in[k] = rem_x_r[k-1];
        den_x_in[k] = den_x_r[k-1];
        q_x_in[k]   = q_x_r[k-1];
        nbit_x[k]   = 1'b0;
        rem_y_in[k] = rem_y_r[k-1];
        den_y_in[k] = den_y_r[k-1];
        q_y_in[k]   = q_y_r[k-1];
        nbit_y[k]   = 1'b0;
        side_in[k]  = side_r[k-1];
      end
      st_x[k] = elt_pkg::div_step(rem_x_in[k], den_x_in[k], nbit_x[k]);
      st_y[k] = elt_pkg::div_step(rem_y_in[k], den_y_in[k], nbit_y[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NStg; k++) begin
      if (en[k]) begin
        rem_x_r[k] <= st_x[k].rem;
        den_x_r[k] <= den_x_in[k];
        q_x_r[k]   <= {q_x_in[k][elt_pkg::QuoW-2:0], st_x[k].qbit};
        rem_y_r[k] <= st_y[k].rem;
        den_y_r[k] <= den_y_in[k];
        q_y_r[k]   <= {q_y_in[k][elt_pkg::QuoW-2:0], st_y[k].qbit};
        side_r[k]  <= side_in[k];
      end
    end
  end

  assign out_quo.side = side_r[NStg-1];
  assign out_quo.qx   = q_x_r[NStg-1];
  assign out_quo.qy   = q_y_r[NStg-1];

endmodule

@@ hw/rtl/elt_shade.sv @@
// ----------------------------------------------------------------------------
// elt_shade
// Three stages: inside test and falloff, tint scaling, divide by 100 and
// clamp into the output register.
// ----------------------------------------------------------------------------
module elt_shade (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  elt_pkg::elt_quo_t in_quo,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [elt_pkg::LumaW-1:0] out_luma,
  output logic              out_inside
);

  localparam int NStg = 3;
  localparam int FallW = elt_pkg::QuoW;
  localparam int ProdW = elt_pkg::GainW + FallW;
  localparam int MulW  = elt_pkg::GainW + 12;

  logic [NStg-1:0] v_r;
  logic [NStg-1:0] en;

  // stage 0
  logic [elt_pkg::LumaW-1:0] luma0_r, luma1_r;
  logic                      neg0_r, neg1_r;
  logic                      inside0_r, inside1_r;
  logic [elt_pkg::GainW-1:0] gain0_r;
  logic [FallW-1:0]          fall0_r;
  logic [elt_pkg::DistW-1:0] d2;
  logic                      inside_nxt;

  // stage 1
  logic [ProdW-1:0]          prod;
  logic [elt_pkg::GainW-1:0] t1_r;

  // stage 2
  logic [MulW-1:0]           mul;
  logic [elt_pkg::MagW-1:0]  mag;
  logic [elt_pkg::LumaW:0]   up;
  logic [elt_pkg::LumaW-1:0] luma_nxt;
  logic [elt_pkg::LumaW-1:0] luma2_r;
  logic                      inside2_r;

  always_comb begin
    en[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready   = en[0];
  assign out_valid  = v_r[NStg-1];
  assign out_luma   = luma2_r;
  assign out_inside = inside2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    d2 = elt_pkg::DistW'(in_quo.qx) + elt_pkg::DistW'(in_quo.qy);
    inside_nxt = in_quo.side.qualify && (d2 <= elt_pkg::DistW'(elt_pkg::UnitDist));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      luma0_r   <= in_quo.side.luma;
      neg0_r    <= in_quo.side.neg;
      gain0_r   <= in_quo.side.gain;
      inside0_r <= inside_nxt;
      // zero falloff outside leaves the sample untouched
      fall0_r   <= inside_nxt ? FallW'(elt_pkg::DistW'(elt_pkg::UnitDist) - d2) : '0;
    end
  end

  // stage 1: |S| * 35 * falloff, drop the 16 fraction bits
  assign prod = ProdW'(gain0_r) * ProdW'(fall0_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      luma1_r   <= luma0_r;
      neg1_r    <= neg0_r;
      inside1_r <= inside0_r;
      t1_r      <= prod[16+elt_pkg::GainW-1:16];
    end
  end

  // stage 2: divide by 100, apply and clamp
  always_comb begin
    mul = MulW'(t1_r) * MulW'(elt_pkg::Div100SMul);
    mag = mul[18+elt_pkg::MagW-1:18];
    up  = {1'b0, luma1_r} + (elt_pkg::LumaW+1)'(mag);
    if (neg1_r) begin
      luma_nxt = (luma1_r >= elt_pkg::LumaW'(mag)) ? (luma1_r - elt_pkg::LumaW'(mag)) : '0;
    end else begin
      luma_nxt = up[elt_pkg::LumaW] ? '1 : up[elt_pkg::LumaW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      luma2_r   <= luma_nxt;
      inside2_r <= inside1_r;
    end
  end

endmodule

@@ hw/rtl/elliptical_luma_tint_mask.sv @@
// ----------------------------------------------------------------------------
// elliptical_luma_tint_mask
// Pipeline from input transfer to result: 4 geometry stages, 17 divider
// stages, 3 shading stages. Throughput: one pixel per cycle while results
// are taken; every stage holds under backpressure and bubbles close up.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// registers with 640 x 480, effect off, neutral style, balanced quality.
// ----------------------------------------------------------------------------
module elliptical_luma_tint_mask (
  input  logic                          clk,
  input  logic                          rst_n,
  elt_pix_if.sink                       in_pix,
  elt_res_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [elt_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [elt_pkg::CfgDataW-1:0]  cfg_wdata
);

  logic [elt_pkg::CfgSizeW-1:0] frame_width_r;
  logic [elt_pkg::CfgSizeW-1:0] frame_height_r;
  logic                         effect_enable_r;
  logic [elt_pkg::StyleW-1:0]   tint_style_r;
  logic [elt_pkg::QualW-1:0]    quality_level_r;
  elt_pkg::elt_cfg_t            cfg;

  logic              geo_valid, geo_ready;
  elt_pkg::elt_geo_t geo;
  logic              quo_valid, quo_ready;
  elt_pkg::elt_quo_t quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= 13'd640;
      frame_height_r  <= 13'd480;
      effect_enable_r <= 1'b0;
      tint_style_r    <= '0;
      quality_level_r <= elt_pkg::QualBalanced;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        elt_pkg::CfgFrameWidth:  frame_width_r   <= cfg_wdata;
        elt_pkg::CfgFrameHeight: frame_height_r  <= cfg_wdata;
        elt_pkg::CfgEffectEn:    effect_enable_r <= cfg_wdata[0];
        elt_pkg::CfgTintStyle:   tint_style_r    <= cfg_wdata[elt_pkg::StyleW-1:0];
        elt_pkg::CfgQuality:     quality_level_r <= cfg_wdata[elt_pkg::QualW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg.frame_width   = frame_width_r;
  assign cfg.frame_height  = frame_height_r;
  assign cfg.effect_enable = effect_enable_r;
  assign cfg.tint_style    = tint_style_r;
  assign cfg.quality_level = quality_level_r;

  elt_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .in_col    (in_pix.pixel_col),
    .in_row    (in_pix.pixel_row),
    .in_luma   (in_pix.luma_in),
    .out_valid (geo_valid),
    .out_ready (geo_ready),
    .out_geo   (geo)
  );

  elt_dist_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (geo_valid),
    .in_ready  (geo_ready),
    .in_geo    (geo),
    .out_valid (quo_valid),
    .out_ready (quo_ready),
    .out_quo   (quo)
  );

  elt_shade u_shade (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (quo_valid),
    .in_ready   (quo_ready),
    .in_quo     (quo),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .out_luma   (out_res.luma_out),
    .out_inside (out_res.inside_mask)
  );

endmodule

@@ dv/tb_elliptical_luma_tint_mask.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elliptical_luma_tint_mask
// Self-checking bench for the elliptical luma tint mask. A scoreboard class
// predicts every transfer from its own copy of the registers; pixels are
// aimed mostly into the ellipse window of the current frame setup, while
// both channels idle at random and the registers change between bursts.
// ----------------------------------------------------------------------------
module tb_elliptical_luma_tint_mask;

  localparam logic [elt_pkg::StyleW-1:0]  StyleNeutral = 3'd0;
  localparam logic [elt_pkg::StyleW-1:0]  StyleSoft    = 3'd1;
  localparam logic [elt_pkg::StyleW-1:0]  StyleBold    = 3'd2;
  localparam logic [elt_pkg::StyleW-1:0]  StyleCool    = 3'd3;
  localparam logic [elt_pkg::StyleW-1:0]  StyleWarm    = 3'd4;
  localparam logic [elt_pkg::StyleW-1:0]  StyleUnused  = 3'd5;
  localparam logic [elt_pkg::QualW-1:0]   QualUnused   = 2'd3;
  localparam logic [elt_pkg::CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam int CycleLimit  = 500000;
  localparam int RandPhases  = 12;
  localparam int PhaseItems  = 50;
  localparam int DrainCycles = 40;

  class luma_tint_checker;
    typedef struct {
      logic [elt_pkg::LumaW-1:0] luma;
      logic                      in_mask;
    } tint_result_t;

    tint_result_t                 tinted_q[$];
    logic [elt_pkg::CfgSizeW-1:0] frame_w;
    logic [elt_pkg::CfgSizeW-1:0] frame_h;
    logic                         enable;
    logic [elt_pkg::StyleW-1:0]   style;
    logic [elt_pkg::QualW-1:0]    quality;
    int                           errors;
    int                           n_results;
    int                           n_inside;

    function new();
      frame_w   = 13'd640;
      frame_h   = 13'd480;
      enable    = 1'b0;
      style     = StyleNeutral;
      quality   = elt_pkg::QualBalanced;
      errors    = 0;
      n_results = 0;
      n_inside  = 0;
    endfunction

    function void write_reg(logic [elt_pkg::CfgIdxW-1:0] idx,
                            logic [elt_pkg::CfgDataW-1:0] data);
      case (idx)
        elt_pkg::CfgFrameWidth:  frame_w = data;
        elt_pkg::CfgFrameHeight: frame_h = data;
        elt_pkg::CfgEffectEn:    enable  = data[0];
        elt_pkg::CfgTintStyle:   style   = data[elt_pkg::StyleW-1:0];
        elt_pkg::CfgQuality:     quality = data[elt_pkg::QualW-1:0];
        default: ;
      endcase
    endfunction

    function longint tint_sum();
      case (style)
        StyleSoft: return 32;
        StyleBold: return -4;
        StyleCool: return 10;
        StyleWarm: return 6;
        default:   return 0;
      endcase
    endfunction

    function void shape(output longint w, h, xc, yc, rx, ry);
      longint cy, fx, fy;
      w = (frame_w > elt_pkg::CfgSizeW'(elt_pkg::MaxWidth)) ?
          longint'(elt_pkg::MaxWidth) : longint'(frame_w);
      h = (frame_h > elt_pkg::CfgSizeW'(elt_pkg::MaxHeight)) ?
          longint'(elt_pkg::MaxHeight) : longint'(frame_h);
      case (quality)
        elt_pkg::QualLite: begin
          cy = 42; fx = 18; fy = 22;
        end
        elt_pkg::QualMax: begin
          cy = 40; fx = 26; fy = 32;
        end
        default: begin
          cy = 42; fx = 22; fy = 28;
        end
      endcase
      xc = (w * 50) / 100;
      yc = (h * cy) / 100;
      rx = (w * fx) / 100;
      ry = (h * fy) / 100;
      if (rx < longint'(elt_pkg::MinRx)) rx = longint'(elt_pkg::MinRx);
      if (ry < longint'(elt_pkg::MinRy)) ry = longint'(elt_pkg::MinRy);
    endfunction

    // half-open window around the ellipse, clipped to the frame
    function bit mask_bounds(output longint x0, x1, y0, y1);
      longint w, h, xc, yc, rx, ry;
      shape(w, h, xc, yc, rx, ry);
      x0 = (xc - rx < 0) ? 0 : xc - rx;
      x1 = (xc + rx > w) ? w : xc + rx;
      y0 = (yc - ry < 0) ? 0 : yc - ry;
      y1 = (yc + ry > h) ? h : yc + ry;
      return (x1 > x0) && (y1 > y0);
    endfunction

    function void predict_tint(logic [elt_pkg::CoordW-1:0] col,
                               logic [elt_pkg::CoordW-1:0] row,
                               logic [elt_pkg::LumaW-1:0] luma);
      tint_result_t r;
      longint s, w, h, xc, yc, rx, ry, x0, x1, y0, y1;
      longint dx, dy, d2, f, mag, v, c, rw, unit;
      r.luma    = luma;
      r.in_mask = 1'b0;
      unit = longint'(elt_pkg::UnitDist);
      s  = tint_sum();
      c  = longint'(col);
      rw = longint'(row);
      if (enable && s != 0 && mask_bounds(x0, x1, y0, y1) &&
          rw >= y0 && rw < y1 && c >= x0 && c < x1) begin
        shape(w, h, xc, yc, rx, ry);
        dx = c - xc;
        dy = rw - yc;
        d2 = (dx * dx * unit) / (rx * rx) + (dy * dy * unit) / (ry * ry);
        if (d2 <= unit) begin
          f   = unit - d2;
          mag = ((s < 0 ? -s : s) * f * 35) / (100 * unit);
          v   = (s < 0) ? longint'(luma) - mag : longint'(luma) + mag;
          if (v < 0)   v = 0;
          if (v > 255) v = 255;
          r.luma    = v[elt_pkg::LumaW-1:0];
          r.in_mask = 1'b1;
        end
      end
      tinted_q.push_back(r);
    endfunction

    function void compare_tint(logic [elt_pkg::LumaW-1:0] luma, logic mask);
      tint_result_t e;
      if (tinted_q.size() == 0) begin
        $error("unexpected result: luma_out %0d inside_mask %0d", luma, mask);
        errors++;
        return;
      end
      e = tinted_q.pop_front();
      n_results++;
      if (mask) n_inside++;
      if (luma !== e.luma) begin
        $error("luma_out mismatch: expected %0d, actual %0d", e.luma, luma);
        errors++;
      end
      if (mask !== e.in_mask) begin
        $error("inside_mask mismatch: expected %0d, actual %0d", e.in_mask, mask);
        errors++;
      end
    endfunction

    function int pending();
      return tinted_q.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [elt_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [elt_pkg::CfgDataW-1:0] cfg_wdata;
  elt_pix_if                    pix_if ();
  elt_res_if                    res_if ();

  luma_tint_checker chk;
  bit      no_idle;
  int      rdy_left;
  int      n_settings;
  longint  cycles;

  elliptical_luma_tint_mask u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      chk.compare_tint(res_if.luma_out, res_if.inside_mask);
  end

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: alternate ready runs and stall runs
  always @(negedge clk) begin
    if (rdy_left > 0) begin
      rdy_left <= rdy_left - 1;
    end else if (no_idle || $urandom_range(0, 99) < 65) begin
      res_if.ready <= 1'b1;
      rdy_left     <= $urandom_range(0, 8);
    end else begin
      res_if.ready <= 1'b0;
      rdy_left     <= idle_len() - 1;
    end
  end

  task automatic send_pixel(input logic [elt_pkg::CoordW-1:0] col,
                            input logic [elt_pkg::CoordW-1:0] row,
                            input logic [elt_pkg::LumaW-1:0] luma);
    int gap;
    gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      pix_if.valid <= 1'b0;
    end
    @(negedge clk);
    pix_if.valid     <= 1'b1;
    pix_if.pixel_col <= col;
    pix_if.pixel_row <= row;
    pix_if.luma_in   <= luma;
    do @(posedge clk); while (!pix_if.ready);
    chk.predict_tint(col, row, luma);
  endtask

  task automatic send_random_pixel();
    longint x0, x1, y0, y1, wl, hl;
    bit has_box;
    int r;
    logic [elt_pkg::CoordW-1:0] col, row;
    logic [elt_pkg::LumaW-1:0] luma;
    has_box = chk.mask_bounds(x0, x1, y0, y1);
    wl = (chk.frame_w > elt_pkg::CfgSizeW'(elt_pkg::MaxWidth)) ?
         longint'(elt_pkg::MaxWidth) : longint'(chk.frame_w);
    hl = (chk.frame_h > elt_pkg::CfgSizeW'(elt_pkg::MaxHeight)) ?
         longint'(elt_pkg::MaxHeight) : longint'(chk.frame_h);
    r  = $urandom_range(0, 99);
    if (r < 70 && has_box) begin
      col = elt_pkg::CoordW'($urandom_range(int'(x1 - 1), int'(x0)));
      row = elt_pkg::CoordW'($urandom_range(int'(y1 - 1), int'(y0)));
    end else if (r < 85 && wl > 0 && hl > 0) begin
      col = elt_pkg::CoordW'($urandom_range(int'(wl - 1), 0));
      row = elt_pkg::CoordW'($urandom_range(int'(hl - 1), 0));
    end else begin
      col = elt_pkg::CoordW'($urandom);
      row = elt_pkg::CoordW'($urandom);
    end
    r = $urandom_range(0, 9);
    luma = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
    send_pixel(col, row, luma);
  endtask

  task automatic cfg_write(input logic [elt_pkg::CfgIdxW-1:0] idx,
                           input logic [elt_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    chk.write_reg(idx, data);
  endtask

  // drop valid, let the pipeline empty, then load every register
  task automatic apply_cfg(input logic [elt_pkg::CfgDataW-1:0] w,
                           input logic [elt_pkg::CfgDataW-1:0] h,
                           input logic en, input logic [elt_pkg::StyleW-1:0] st,
                           input logic [elt_pkg::QualW-1:0] q);
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    cfg_write(elt_pkg::CfgFrameWidth, w);
    cfg_write(elt_pkg::CfgFrameHeight, h);
    cfg_write(elt_pkg::CfgEffectEn, elt_pkg::CfgDataW'(en));
    cfg_write(elt_pkg::CfgTintStyle, elt_pkg::CfgDataW'(st));
    cfg_write(elt_pkg::CfgQuality, elt_pkg::CfgDataW'(q));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [elt_pkg::CfgDataW-1:0] pick_frame_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return elt_pkg::CfgDataW'($urandom_range(1, 64));
    if (r < 8) return elt_pkg::CfgDataW'($urandom_range(65, elt_pkg::MaxWidth));
    if (r == 8) return elt_pkg::CfgDataW'(elt_pkg::MaxWidth);
    return elt_pkg::CfgDataW'($urandom_range(elt_pkg::MaxWidth + 1, 8191));
  endfunction

  initial begin
    logic [elt_pkg::CfgDataW-1:0] w, h;
    logic en;
    logic [elt_pkg::StyleW-1:0] st;
    logic [elt_pkg::QualW-1:0] q;
    int r;

    chk        = new();
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    pix_if.valid     = 1'b0;
    pix_if.pixel_col = '0;
    pix_if.pixel_row = '0;
    pix_if.luma_in   = '0;
    res_if.ready     = 1'b0;
    rdy_left   = 0;
    no_idle    = 1'b0;
    n_settings = 0;
    cycles     = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: effect off, everything passes
    send_pixel(12'd0, 12'd0, 8'd0);
    send_pixel(12'd4095, 12'd4095, 8'd255);
    send_pixel(12'd320, 12'd201, 8'd128);
    // index past the register list must be ignored
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    cfg_write(CfgIdxUnused, 13'h1FFF);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_pixel(12'd320, 12'd201, 8'd77);

    // soft: clamp high at center, falloff zero on the rim, outside, off frame
    apply_cfg(13'd640, 13'd480, 1'b1, StyleSoft, elt_pkg::QualBalanced);
    send_pixel(12'd320, 12'd201, 8'd250);
    send_pixel(12'd320, 12'd201, 8'd0);
    send_pixel(12'd180, 12'd201, 8'd90);
    send_pixel(12'd459, 12'd201, 8'd90);
    send_pixel(12'd179, 12'd201, 8'd90);
    send_pixel(12'd4095, 12'd4095, 8'd200);

    // bold darkens: clamp low
    apply_cfg(13'd640, 13'd480, 1'b1, StyleBold, elt_pkg::QualBalanced);
    send_pixel(12'd320, 12'd201, 8'd0);
    send_pixel(12'd320, 12'd201, 8'd255);

    apply_cfg(13'd640, 13'd480, 1'b1, StyleCool, elt_pkg::QualLite);
    send_pixel(12'd320, 12'd201, 8'd100);
    apply_cfg(13'd640, 13'd480, 1'b1, StyleWarm, elt_pkg::QualMax);
    send_pixel(12'd320, 12'd192, 8'd100);
    apply_cfg(13'd640, 13'd480, 1'b1, StyleSoft, QualUnused);
    send_pixel(12'd320, 12'd201, 8'd100);
    apply_cfg(13'd640, 13'd480, 1'b1, StyleUnused, elt_pkg::QualBalanced);
    send_pixel(12'd320, 12'd201, 8'd100);
    apply_cfg(13'd640, 13'd480, 1'b1, StyleNeutral, elt_pkg::QualBalanced);
    send_pixel(12'd320, 12'd201, 8'd100);

    for (int p = 0; p < RandPhases; p++) begin
      w  = pick_frame_size();
      h  = pick_frame_size();
      en = ($urandom_range(0, 9) != 0);
      r  = $urandom_range(0, 9);
      st = (r == 0) ? StyleNeutral : (r == 1) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(1, 4));
      q  = elt_pkg::QualW'($urandom_range(0, 3));
      // size extremes first: tiny, full, oversize, zero, narrow and tall
      case (p)
        0: begin w = 13'd1;    h = 13'd1;    end
        1: begin w = 13'd4096; h = 13'd4096; end
        2: begin w = 13'd8191; h = 13'd8191; end
        3: begin w = 13'd0;    h = 13'd0;    end
        4: begin w = 13'd16;   h = 13'd4096; end
        default: ;
      endcase
      if (p < 5) begin
        en = 1'b1;
        st = 3'($urandom_range(1, 4));
      end
      apply_cfg(w, h, en, st, q);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (PhaseItems) send_random_pixel();
    end

    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d results over %0d register setups, %0d inside the ellipse.",
             chk.n_results, n_settings, chk.n_inside);
    if (chk.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/elt_pkg.sv
hw/rtl/elt_pix_if.sv
hw/rtl/elt_res_if.sv
hw/rtl/elt_geom.sv
hw/rtl/elt_dist_div.sv
hw/rtl/elt_shade.sv
hw/rtl/elliptical_luma_tint_mask.sv
dv/tb_elliptical_luma_tint_mask.sv
